// ----- hdl/raycast_wall_column_setup_unit_assert.svh -----
// assertion macros for the wall column setup block
`ifndef RAYCAST_WALL_COLUMN_SETUP_UNIT_ASSERT_SVH
`define RAYCAST_WALL_COLUMN_SETUP_UNIT_ASSERT_SVH

// same-cycle implication
`define RCWCS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RCWCS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/rcwcs_pkg.sv -----
// types, constants and cordic / divider step functions for the wall column setup block
`default_nettype none
package rcwcs_pkg;

   localparam int unsigned TILE_SIZE_DEF     = 64;
   localparam int unsigned SCREEN_HEIGHT_DEF = 512;

   localparam int unsigned CORDIC_STEPS = 14;
   localparam logic signed [17:0] CORDIC_GAIN = 18'sd19899;

   localparam logic signed [17:0] ATAN_TURNS [CORDIC_STEPS] = '{
      18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163,
      18'sd81, 18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1
   };

   // wall texture codes
   localparam logic [1:0] TEX_SOUTH = 2'd0;
   localparam logic [1:0] TEX_NORTH = 2'd1;
   localparam logic [1:0] TEX_WEST  = 2'd2;
   localparam logic [1:0] TEX_EAST  = 2'd3;

   typedef struct packed {
      logic signed [17:0] x;
      logic signed [17:0] y;
      logic signed [17:0] z;
   } rot_type;

   typedef struct packed {
      logic               neg;
      logic signed [17:0] z;
   } fold_type;

   typedef struct packed {
      logic [27:0] rem;
      logic [15:0] quo;
   } div_type;

   typedef struct packed {
      logic [5:0] tcol;
      logic [1:0] tsel;
   } tex_type;

   // fold a turn fraction into a half turn around zero
   function automatic fold_type angle_fold(input logic [15:0] ang);
      fold_type           r;
      logic signed [17:0] a;
      a = 18'($signed(ang));
      r.neg = 1'b0;
      if (a > 18'sd16384) begin
         a = a - 18'sd32768;
         r.neg = 1'b1;
      end else if (a < -18'sd16384) begin
         a = a + 18'sd32768;
         r.neg = 1'b1;
      end
      r.z = a;
      return r;
   endfunction

   function automatic rot_type cordic_step(input rot_type v, input logic [3:0] i);
      rot_type            r;
      logic signed [17:0] sx;
      logic signed [17:0] sy;
      sx = v.y >>> i;
      sy = v.x >>> i;
      if (!v.z[17]) begin
         r.x = v.x - sx;
         r.y = v.y + sy;
         r.z = v.z - ATAN_TURNS[i];
      end else begin
         r.x = v.x + sx;
         r.y = v.y - sy;
         r.z = v.z + ATAN_TURNS[i];
      end
      return r;
   endfunction

   // one restoring divide step, one numerator bit shifted in
   function automatic div_type div_step(input div_type v, input logic [26:0] d,
                                        input logic b);
      div_type     r;
      logic [27:0] t;
      t = {v.rem[26:0], b};
      if (t >= {1'b0, d}) begin
         r.rem = t - {1'b0, d};
         r.quo = {v.quo[14:0], 1'b1};
      end else begin
         r.rem = t;
         r.quo = {v.quo[14:0], 1'b0};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/raycast_wall_column_setup_unit.sv -----
// Wall column projection for a grid raycaster. Each req word carries one screen column's ray
// hit point, ray angle, player position and view angle; the matching rsp word carries the
// fisheye-corrected wall slice: clamped top and bottom rows, unclamped height (saturating at
// 65535, also for a distance at or below zero), the rows cut off above the screen, the texture
// column and which of four wall textures to use. The block takes one word every cycle while
// rsp is not stalled and offers each result in order through 22 register stages: two
// 14-step sine/cosine cordics run two steps per stage, then the rotation and fisheye
// multiplies, then a 16-step restoring divider at two steps per stage. A stalled rsp side
// freezes the whole pipeline, nothing is dropped. TILE_SIZE is world units per tile and the
// texture width, SCREEN_HEIGHT the rows.
`default_nettype none
`include "raycast_wall_column_setup_unit_assert.svh"
module raycast_wall_column_setup_unit import rcwcs_pkg::*; #(
   parameter int unsigned TILE_SIZE     = TILE_SIZE_DEF,
   parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // column_index, view_angle, ray_angle, hit_x, hit_y, player_x, player_y, zero pad
   input  wire logic [111:0] req_tdata,
   // horiz_hit, step_y_positive, step_x_positive
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_column, top_row, bottom_row, texture_offset, full_height, texture_column, zero pad
   output logic [71:0]       rsp_tdata,
   // texture_select
   output logic [1:0]        rsp_tuser
);

   localparam int LAST = 21;   // output register stage
   localparam int CORD = 7;    // last cordic stage
   localparam int DIV0 = 12;   // divider setup stage

   // projection numerator tile * rows * 256, and its part above the 16 quotient bits
   localparam logic [27:0] NUM    = 28'(TILE_SIZE * SCREEN_HEIGHT * 256);
   localparam logic [11:0] NUM_HI = NUM[27:16];
   // reciprocal for the texture modulo, exact for 12-bit tile coordinates
   localparam logic [21:0] RECIP  = 22'((2 ** 24 + TILE_SIZE - 1) / TILE_SIZE);
   localparam logic [8:0]  TILE9  = 9'(TILE_SIZE);
   localparam logic [16:0] SH17   = 17'(SCREEN_HEIGHT);

   logic adv;
   logic [LAST:0] valid_ff;

   // input fields
   logic [9:0]  in_col;
   logic [15:0] in_view, in_ray, in_hx, in_hy, in_px, in_py;
   assign in_col  = req_tdata[9:0];
   assign in_view = req_tdata[25:10];
   assign in_ray  = req_tdata[41:26];
   assign in_hx   = req_tdata[57:42];
   assign in_hy   = req_tdata[73:58];
   assign in_px   = req_tdata[89:74];
   assign in_py   = req_tdata[105:90];

   // the whole pipeline moves when the output word is free or being taken
   assign adv        = !valid_ff[LAST] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[LAST-1:0], req_tvalid};
      end
   end

   // column index rides alongside
   logic [9:0] col_ff [0:LAST];
   always_ff @(posedge clock) begin
      if (adv) begin
         col_ff[0] <= in_col;
         for (int s = 1; s <= LAST; s++) begin
            col_ff[s] <= col_ff[s-1];
         end
      end
   end

   // texture path: pick coordinate, reciprocal multiply, then remainder and mirror
   logic [11:0] texv0_ff, texv1_ff;
   logic [2:0]  flags0_ff, flags1_ff;
   logic [33:0] texq1_ff;
   tex_type     tex_ff [2:LAST];
   tex_type     tex2_in;
   logic [9:0]  tq;
   logic [11:0] trem;
   logic [7:0]  tbase;
   logic [7:0]  tmir;

   always_comb begin
      tq    = texq1_ff[33:24];
      trem  = 12'(21'(texv1_ff) - 21'(tq) * 21'(TILE9));
      tbase = trem[7:0];
      tmir  = 8'(TILE9 - 9'd1 - 9'(tbase));
      if (flags1_ff[0]) begin
         tex2_in.tcol = flags1_ff[1] ? tmir[5:0] : tbase[5:0];
         tex2_in.tsel = flags1_ff[1] ? TEX_SOUTH : TEX_NORTH;
      end else begin
         tex2_in.tcol = flags1_ff[2] ? tbase[5:0] : tmir[5:0];
         tex2_in.tsel = flags1_ff[2] ? TEX_WEST : TEX_EAST;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         texv0_ff  <= req_tuser[0] ? in_hx[15:4] : in_hy[15:4];
         flags0_ff <= req_tuser;
         texv1_ff  <= texv0_ff;
         flags1_ff <= flags0_ff;
         texq1_ff  <= 34'(texv0_ff) * 34'(RECIP);
         tex_ff[2] <= tex2_in;
         for (int s = 3; s <= LAST; s++) begin
            tex_ff[s] <= tex_ff[s-1];
         end
      end
   end

   // stage 0: fold both angles, form hit offsets
   rot_type            ray_ff  [0:CORD];
   rot_type            fish_ff [0:CORD];
   logic [CORD:0]      rneg_ff, fneg_ff;
   logic signed [16:0] dx_ff [0:CORD];
   logic signed [16:0] dy_ff [0:CORD];
   fold_type           ray_fold_in, fish_fold_in;

   always_comb begin
      ray_fold_in  = angle_fold(in_ray);
      fish_fold_in = angle_fold(in_view - in_ray);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ray_ff[0]  <= '{x: CORDIC_GAIN, y: 18'sd0, z: ray_fold_in.z};
         fish_ff[0] <= '{x: CORDIC_GAIN, y: 18'sd0, z: fish_fold_in.z};
         rneg_ff[0] <= ray_fold_in.neg;
         fneg_ff[0] <= fish_fold_in.neg;
         dx_ff[0]   <= $signed({1'b0, in_hx}) - $signed({1'b0, in_px});
         dy_ff[0]   <= $signed({1'b0, in_hy}) - $signed({1'b0, in_py});
      end
   end

   // stages 1..7: two cordic iterations each for ray and fisheye angles
   for (genvar s = 1; s <= CORD; s++) begin : g_cordic
      rot_type ray_mid, ray_in, fish_mid, fish_in;
      always_comb begin
         ray_mid  = cordic_step(ray_ff[s-1], 4'(2 * s - 2));
         ray_in   = cordic_step(ray_mid, 4'(2 * s - 1));
         fish_mid = cordic_step(fish_ff[s-1], 4'(2 * s - 2));
         fish_in  = cordic_step(fish_mid, 4'(2 * s - 1));
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            ray_ff[s]  <= ray_in;
            fish_ff[s] <= fish_in;
            rneg_ff[s] <= rneg_ff[s-1];
            fneg_ff[s] <= fneg_ff[s-1];
            dx_ff[s]   <= dx_ff[s-1];
            dy_ff[s]   <= dy_ff[s-1];
         end
      end
   end

   // stages 8..11: rotate the offset, apply fisheye cosine, scale to q.8 distance
   logic signed [17:0] cr_in, sr_in, cf_in;
   logic signed [34:0] p1_ff, p2_ff;
   logic signed [17:0] cf8_ff, cf9_ff;
   logic signed [35:0] rot_ff;
   logic signed [35:0] mh_ff;
   logic signed [36:0] ml_ff;
   logic signed [53:0] prod_in;
   logic signed [27:0] dist_ff;

   always_comb begin
      cr_in   = rneg_ff[CORD] ? -ray_ff[CORD].x : ray_ff[CORD].x;
      sr_in   = rneg_ff[CORD] ? -ray_ff[CORD].y : ray_ff[CORD].y;
      cf_in   = fneg_ff[CORD] ? -fish_ff[CORD].x : fish_ff[CORD].x;
      prod_in = (54'(mh_ff) <<< 18) + 54'(ml_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff   <= 35'(cr_in) * 35'(dx_ff[CORD]);
         p2_ff   <= 35'(sr_in) * 35'(dy_ff[CORD]);
         cf8_ff  <= cf_in;
         rot_ff  <= 36'(p1_ff) - 36'(p2_ff);
         cf9_ff  <= cf8_ff;
         // split the 36-bit offset so each multiply stays narrow
         mh_ff   <= 36'(cf9_ff) * 36'($signed(rot_ff[35:18]));
         ml_ff   <= 37'(cf9_ff) * 37'($signed({1'b0, rot_ff[17:0]}));
         dist_ff <= prod_in[53:26];
      end
   end

   // stage 12: saturation check and divider setup; stages 13..20: two quotient bits each
   div_type     dv_ff  [DIV0:LAST-1];
   logic [26:0] den_ff [DIV0:LAST-1];
   logic [LAST-1:DIV0] sat_ff;
   logic        nonpos_in, near_in;

   always_comb begin
      nonpos_in = dist_ff[27] || (dist_ff == 28'sd0);
      near_in   = !dist_ff[27] && (dist_ff[26:0] <= 27'(NUM_HI));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sat_ff[DIV0] <= nonpos_in || near_in;
         den_ff[DIV0] <= dist_ff[26:0];
         dv_ff[DIV0]  <= '{rem: 28'(NUM_HI), quo: 16'd0};
      end
   end

   for (genvar s = DIV0 + 1; s <= LAST - 1; s++) begin : g_div
      div_type dmid, dnext;
      always_comb begin
         dmid  = div_step(dv_ff[s-1], den_ff[s-1], NUM[15 - 2 * (s - DIV0 - 1)]);
         dnext = div_step(dmid, den_ff[s-1], NUM[14 - 2 * (s - DIV0 - 1)]);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ff[s]  <= dnext;
            den_ff[s] <= den_ff[s-1];
            sat_ff[s] <= sat_ff[s-1];
         end
      end
   end

   // stage 21: clamp height, center on screen, register the rsp word
   logic [16:0] full_in, h_in, toff_in, bot_in, top_in;
   logic        over_in;
   logic [9:0]  top_ff, bot_ff;
   logic [15:0] toff_ff, full_ff;

   always_comb begin
      full_in = sat_ff[LAST-1] ? 17'hFFFF : {1'b0, dv_ff[LAST-1].quo};
      over_in = full_in > SH17;
      h_in    = over_in ? SH17 : full_in;
      toff_in = over_in ? ((full_in - SH17) >> 1) : 17'd0;
      bot_in  = SH17 - ((SH17 >> 1) - (h_in >> 1));
      top_in  = bot_in - h_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         top_ff  <= top_in[9:0];
         bot_ff  <= bot_in[9:0];
         toff_ff <= toff_in[15:0];
         full_ff <= full_in[15:0];
      end
   end

   assign rsp_tvalid = valid_ff[LAST];
   assign rsp_tdata  = {4'd0, tex_ff[LAST].tcol, full_ff, toff_ff, bot_ff, top_ff, col_ff[LAST]};
   assign rsp_tuser  = tex_ff[LAST].tsel;

   `RCWCS_ASSERT_NXT(a_stall_holds, clock, reset, !adv, $stable(valid_ff),
      "pipeline valid bits moved during stall")
   `RCWCS_ASSERT_IMP(a_div_start, clock, reset, valid_ff[DIV0] && !sat_ff[DIV0],
      dv_ff[DIV0].rem < {1'b0, den_ff[DIV0]}, "divider start remainder not below divisor")
   `RCWCS_ASSERT_IMP(a_div_end, clock, reset, valid_ff[LAST-1] && !sat_ff[LAST-1],
      dv_ff[LAST-1].rem < {1'b0, den_ff[LAST-1]}, "divider remainder not below divisor")
   `RCWCS_ASSERT_IMP(a_cordic_conv, clock, reset, valid_ff[CORD],
      ray_ff[CORD].z < 18'sd1024 && ray_ff[CORD].z > -18'sd1024 &&
      fish_ff[CORD].z < 18'sd1024 && fish_ff[CORD].z > -18'sd1024,
      "cordic residual angle did not converge")

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// testbench for the wall column setup block: directed and random columns, scoreboard check
`default_nettype none
module testbench import rcwcs_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TILE   = 64;
   localparam int unsigned SCREEN = 512;
   localparam int unsigned LATENCY = 22;
   localparam int unsigned RANDOM_WORDS = 1430;

   // one ray hit as it enters the block
   typedef struct {
      logic [9:0]  column;
      logic [15:0] view;
      logic [15:0] ray;
      logic [15:0] hit_x;
      logic [15:0] hit_y;
      logic [15:0] player_x;
      logic [15:0] player_y;
      logic        horizontal;
      logic        y_positive;
      logic        x_positive;
   } ray_hit_type;

   // one projected wall slice as it leaves the block
   typedef struct {
      logic [9:0]  column;
      logic [9:0]  top_row;
      logic [9:0]  bottom_row;
      logic [15:0] tex_offset;
      logic [15:0] full_height;
      logic [5:0]  tex_column;
      logic [1:0]  tex_select;
   } wall_slice_type;

   // arctangent steps in turn units
   localparam longint ARCTAN_STEP [14] = '{
      8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1
   };

   // cordic sine and cosine, q1.15
   function automatic void trig_q15(input logic [15:0] ang, output longint c,
                                    output longint s);
      longint a;
      longint x;
      longint y;
      longint dx;
      longint dy;
      bit     flip;
      a = ang;
      flip = 0;
      x = 19899;
      y = 0;
      if (a >= 32768) a = a - 65536;
      if (a > 16384) begin
         a = a - 32768;
         flip = 1;
      end else if (a < -16384) begin
         a = a + 32768;
         flip = 1;
      end
      for (int i = 0; i < 14; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (a >= 0) begin
            x = x - dx;
            y = y + dy;
            a = a - ARCTAN_STEP[i];
         end else begin
            x = x + dx;
            y = y - dy;
            a = a + ARCTAN_STEP[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // project one ray hit into a wall slice
   function automatic wall_slice_type project_slice(input ray_hit_type h);
      wall_slice_type w;
      longint         cr;
      longint         sr;
      longint         cf;
      longint         sf;
      longint         depth;
      longint         full;
      longint         clamp;
      longint         bottom;
      longint         base;
      trig_q15(h.ray, cr, sr);
      trig_q15(h.view - h.ray, cf, sf);
      depth = (cf * (cr * (longint'(h.hit_x) - longint'(h.player_x))
                   - sr * (longint'(h.hit_y) - longint'(h.player_y)))) >>> 26;
      if (depth <= 0) full = 65535;
      else begin
         full = (longint'(TILE) * SCREEN * 256) / depth;
         if (full > 65535) full = 65535;
      end
      clamp = full;
      w.tex_offset = '0;
      if (clamp > SCREEN) begin
         w.tex_offset = 16'((clamp - SCREEN) / 2);
         clamp = SCREEN;
      end
      bottom = SCREEN - (SCREEN / 2 - clamp / 2);
      w.column = h.column;
      w.bottom_row = 10'(bottom);
      w.top_row = 10'(bottom - clamp);
      w.full_height = 16'(full);
      if (h.horizontal) begin
         base = (h.hit_x >> 4) % TILE;
         w.tex_column = 6'(h.y_positive ? TILE - 1 - base : base);
         w.tex_select = h.y_positive ? TEX_SOUTH : TEX_NORTH;
      end else begin
         base = (h.hit_y >> 4) % TILE;
         w.tex_column = 6'(h.x_positive ? base : TILE - 1 - base);
         w.tex_select = h.x_positive ? TEX_WEST : TEX_EAST;
      end
      return w;
   endfunction

   class slice_scoreboard;
      wall_slice_type pending[$];
      int             errors = 0;

      function void note_hit(ray_hit_type h);
         pending.push_back(project_slice(h));
      endfunction

      function void check_slice(wall_slice_type got);
         wall_slice_type want;
         if (pending.size() == 0) begin
            $error("unexpected rsp word for column %0d", got.column);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.column !== want.column) begin
            $error("out_column: expected %0d, got %0d", want.column, got.column);
            errors++;
         end
         if (got.top_row !== want.top_row) begin
            $error("top_row: expected %0d, got %0d", want.top_row, got.top_row);
            errors++;
         end
         if (got.bottom_row !== want.bottom_row) begin
            $error("bottom_row: expected %0d, got %0d", want.bottom_row, got.bottom_row);
            errors++;
         end
         if (got.tex_offset !== want.tex_offset) begin
            $error("texture_offset: expected %0d, got %0d", want.tex_offset, got.tex_offset);
            errors++;
         end
         if (got.full_height !== want.full_height) begin
            $error("full_height: expected %0d, got %0d", want.full_height, got.full_height);
            errors++;
         end
         if (got.tex_column !== want.tex_column) begin
            $error("texture_column: expected %0d, got %0d", want.tex_column, got.tex_column);
            errors++;
         end
         if (got.tex_select !== want.tex_select) begin
            $error("texture_select: expected %0d, got %0d", want.tex_select, got.tex_select);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [71:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   slice_scoreboard board = new();
   bit              stim_done = 0;

   always #2 clock = ~clock;

   raycast_wall_column_setup_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // watch both channels at the rising edge
   always @(posedge clock) begin
      ray_hit_type    h;
      wall_slice_type w;
      if (!reset && req_tvalid && req_tready) begin
         h.column = req_tdata[9:0];
         h.view = req_tdata[25:10];
         h.ray = req_tdata[41:26];
         h.hit_x = req_tdata[57:42];
         h.hit_y = req_tdata[73:58];
         h.player_x = req_tdata[89:74];
         h.player_y = req_tdata[105:90];
         h.horizontal = req_tuser[0];
         h.y_positive = req_tuser[1];
         h.x_positive = req_tuser[2];
         board.note_hit(h);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         w.column = rsp_tdata[9:0];
         w.top_row = rsp_tdata[19:10];
         w.bottom_row = rsp_tdata[29:20];
         w.tex_offset = rsp_tdata[45:30];
         w.full_height = rsp_tdata[61:46];
         w.tex_column = rsp_tdata[67:62];
         w.tex_select = rsp_tuser;
         board.check_slice(w);
      end
   end

   // offer one word and hold it until taken; leaves valid high
   task automatic send_hit(input ray_hit_type h);
      req_tvalid = 1'b1;
      req_tdata = {6'd0, h.player_y, h.player_x, h.hit_y, h.hit_x, h.ray, h.view, h.column};
      req_tuser = {h.x_positive, h.y_positive, h.horizontal};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // burst gaps: valid drops for a random number of cycles
   task automatic sender_gap();
      int n;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (n > 0) begin
         req_tvalid = 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   function automatic ray_hit_type make_hit(input logic [9:0] col, input logic [15:0] view,
                                            input logic [15:0] ray, input logic [15:0] hx,
                                            input logic [15:0] hy, input logic [15:0] px,
                                            input logic [15:0] py, input logic [2:0] flags);
      ray_hit_type h;
      h.column = col;
      h.view = view;
      h.ray = ray;
      h.hit_x = hx;
      h.hit_y = hy;
      h.player_x = px;
      h.player_y = py;
      h.horizontal = flags[0];
      h.y_positive = flags[1];
      h.x_positive = flags[2];
      return h;
   endfunction

   // a hit placed ahead of the player along the ray, view near the ray
   function automatic ray_hit_type aimed_hit();
      ray_hit_type h;
      real         ang;
      real         r;
      int          hx;
      int          hy;
      h.column = 10'($urandom);
      h.ray = 16'($urandom);
      h.view = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                           : 16'(h.ray + $urandom_range(0, 10922) - 5461);
      h.player_x = 16'($urandom_range(4096, 61439));
      h.player_y = 16'($urandom_range(4096, 61439));
      ang = 6.283185307179586 * h.ray / 65536.0;
      // mostly near walls so heights span clamped and unclamped
      r = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200) : $urandom_range(16, 4000);
      hx = int'(h.player_x + r * $cos(ang));
      hy = int'(h.player_y - r * $sin(ang));
      h.hit_x = 16'((hx < 0) ? 0 : (hx > 65535) ? 65535 : hx);
      h.hit_y = 16'((hy < 0) ? 0 : (hy > 65535) ? 65535 : hy);
      {h.x_positive, h.y_positive, h.horizontal} = 3'($urandom);
      return h;
   endfunction

   // receiver: random stall pattern, one long hold-off, stretches always ready
   initial begin
      int cyc;
      cyc = 0;
      @(negedge clock);
      while (1) begin
         if (cyc == 300) begin
            rsp_tready = 1'b0;
            repeat (120) @(negedge clock);
         end
         if ((cyc / 200) % 3 == 1) rsp_tready = 1'b1;
         else rsp_tready = ($urandom_range(0, 3) != 0);
         cyc++;
         @(negedge clock);
      end
   end

   initial begin
      ray_hit_type h;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: cardinal angles, zero distance, very close and far walls, all textures
      send_hit(make_hit(10'd0, 16'd0, 16'd0, 16'd16400, 16'd1000, 16'd1000, 16'd1000, 3'b000));
      send_hit(make_hit(10'd1023, 16'd16384, 16'd16384, 16'd1000, 16'd1000, 16'd1000,
                        16'd17000, 3'b001));
      send_hit(make_hit(10'd5, 16'd32768, 16'd32768, 16'd0, 16'd500, 16'd30000, 16'd500,
                        3'b011));
      send_hit(make_hit(10'd6, 16'd49152, 16'd49152, 16'd700, 16'd65535, 16'd700, 16'd0,
                        3'b100));
      send_hit(make_hit(10'd7, 16'd65535, 16'd65535, 16'd65535, 16'd9, 16'd0, 16'd9,
                        3'b110));
      // hit at the eye and behind the player saturate
      send_hit(make_hit(10'd8, 16'd0, 16'd0, 16'd800, 16'd800, 16'd800, 16'd800, 3'b111));
      send_hit(make_hit(10'd9, 16'd0, 16'd0, 16'd100, 16'd800, 16'd60000, 16'd800, 3'b010));
      send_hit(make_hit(10'd10, 16'd0, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd0, 3'b101));
      // very close: height beyond screen and beyond the field
      send_hit(make_hit(10'd11, 16'd0, 16'd0, 16'd1001, 16'd0, 16'd1000, 16'd0, 3'b000));
      send_hit(make_hit(10'd12, 16'd0, 16'd0, 16'd1300, 16'd0, 16'd1000, 16'd0, 3'b001));
      send_hit(make_hit(10'd13, 16'd0, 16'd0, 16'd2040, 16'd0, 16'd1000, 16'd0, 3'b100));
      // exactly screen height and just below
      send_hit(make_hit(10'd14, 16'd0, 16'd0, 16'd2024, 16'd7, 16'd1000, 16'd7, 3'b110));
      send_hit(make_hit(10'd15, 16'd0, 16'd0, 16'd2026, 16'd7, 16'd1000, 16'd7, 3'b011));
      // fisheye at wide view offset and at a half turn
      send_hit(make_hit(10'd16, 16'd8192, 16'd0, 16'd9000, 16'd0, 16'd1000, 16'd0, 3'b000));
      send_hit(make_hit(10'd17, 16'd32768, 16'd0, 16'd9000, 16'd0, 16'd1000, 16'd0, 3'b000));
      send_hit(make_hit(10'd18, 16'd16385, 16'd0, 16'd9000, 16'd0, 16'd1000, 16'd0, 3'b000));
      send_hit(make_hit(10'd19, 16'd0, 16'd49151, 16'd2000, 16'd5000, 16'd2000, 16'd1000,
                        3'b101));
      send_hit(make_hit(10'd20, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA,
                        3'b010));

      for (int k = 0; k < RANDOM_WORDS; k++) begin
         sender_gap();
         if ($urandom_range(0, 9) == 0) begin
            h = make_hit(10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
         end else begin
            h = aimed_hit();
         end
         send_hit(h);
      end
      req_tvalid = 1'b0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (board.errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // run limit
   initial begin
      #2ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire

// ----- files.f -----
+incdir+hdl
hdl/rcwcs_pkg.sv
hdl/raycast_wall_column_setup_unit.sv
sim/testbench.sv
